### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk_i, reset on rst_ni.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### rtl/core/ddq_pkg.sv
// ----------------------------------------------------------------------------
// ddq_pkg
// Types, sizes and helpers for the deque with lazy reversal.
// ----------------------------------------------------------------------------
package ddq_pkg;

  localparam int Depth = 1024;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);
  localparam int DataW = 16;

  typedef enum logic [2:0] {
    FnAppend  = 3'd0,
    FnReverse = 3'd1,
    FnDelete  = 3'd2,
    FnRead    = 3'd3,
    FnClear   = 3'd4
  } func_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StError    = 2'd1,
    StOverflow = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0]       func;
    logic [DataW-1:0] value_in;
  } ddq_in_t;

  typedef struct packed {
    logic [DataW-1:0] value_out;
    logic             has_value;
    logic             is_last;
    logic [1:0]       status;
    logic [10:0]      count_left;
  } ddq_out_t;

  function automatic logic [AddrW-1:0] wrap_idx(input logic [CntW:0] i);
    logic [CntW:0] r;
    r = (i >= (CntW+1)'(Depth)) ? i - (CntW+1)'(Depth) : i;
    return r[AddrW-1:0];
  endfunction

endpackage

### rtl/core/ddq_ram.sv
// ----------------------------------------------------------------------------
// ddq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module ddq_ram #(
  parameter int Width = 16,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/deque_with_lazy_reverse.sv
// ----------------------------------------------------------------------------
// deque_with_lazy_reverse
// Ring-buffer deque in one RAM, with a lazy orientation bit and sticky error.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// command   in   start & !busy           req_i  (func, value_in)
// result    out  valid_o, one cycle      res_o  (value_out, has_value,
//                                                is_last, status, count_left)
//
// One item per cycle; each result is registered and appears in the cycle after
// its transfer, with read data from the registered read port of the element RAM.
// Pointers, count and flags update at the transfer edge, so a RAM write
// always lands before any later read; busy stays low.
// Reset clears pointers and flags; RAM contents are left as they are.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module deque_with_lazy_reverse (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  ddq_pkg::ddq_in_t req_i,
  output logic             valid_o,
  output ddq_pkg::ddq_out_t res_o
);
  import ddq_pkg::*;

  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             rev_q, rev_d;
  logic             err_q, err_d;
  logic             valid_q;
  logic             has_q, has_d;
  logic             last_q, last_d;
  logic [1:0]       status_q, status_d;
  logic [CntW-1:0]  cntout_q;

  logic             accept, ovf, pop;
  logic             mem_en, mem_we;
  logic [AddrW-1:0] mem_addr, tail_addr, back_addr, front_addr;
  logic [DataW-1:0] mem_rdata;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  assign tail_addr  = wrap_idx((CntW+1)'(head_q) + (CntW+1)'(cnt_q));
  assign back_addr  = wrap_idx((CntW+1)'(head_q) + (CntW+1)'(cnt_q) - (CntW+1)'(1));
  assign front_addr = rev_q ? back_addr : head_q;

  always_comb begin
    head_d   = head_q;
    cnt_d    = cnt_q;
    rev_d    = rev_q;
    err_d    = err_q;
    ovf      = 1'b0;
    pop      = 1'b0;
    has_d    = 1'b0;
    mem_en   = 1'b0;
    mem_we   = 1'b0;
    mem_addr = front_addr;
    if (accept) begin
      unique case (func_e'(req_i.func))
        FnAppend: begin
          if (cnt_q >= CntW'(Depth)) begin
            ovf = 1'b1;
          end else begin
            mem_en   = 1'b1;
            mem_we   = 1'b1;
            mem_addr = tail_addr;
            cnt_d    = cnt_q + CntW'(1);
          end
        end
        FnReverse: begin
          if (!err_q) rev_d = ~rev_q;
        end
        FnDelete: begin
          if (!err_q) begin
            if (cnt_q == '0) err_d = 1'b1;
            else pop = 1'b1;
          end
        end
        FnRead: begin
          if (cnt_q != '0) begin
            pop    = 1'b1;
            has_d  = 1'b1;
            mem_en = 1'b1;
          end
        end
        FnClear: begin
          head_d = '0;
          cnt_d  = '0;
          rev_d  = 1'b0;
          err_d  = 1'b0;
        end
        default: begin
        end
      endcase
      if (pop) begin
        cnt_d = cnt_q - CntW'(1);
        if (!rev_q) head_d = wrap_idx((CntW+1)'(head_q) + (CntW+1)'(1));
      end
    end
  end

  always_comb begin
    last_d = has_d && (cnt_d == '0);
    if (ovf) status_d = StOverflow;
    else if (err_d) status_d = StError;
    else status_d = StOk;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      cnt_q   <= '0;
      rev_q   <= 1'b0;
      err_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      rev_q   <= rev_d;
      err_q   <= err_d;
      valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      has_q    <= has_d;
      last_q   <= last_d;
      status_q <= status_d;
      cntout_q <= cnt_d;
    end
  end

  ddq_ram #(
    .Width (DataW),
    .Depth (Depth)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (req_i.value_in),
    .rdata_o (mem_rdata)
  );

  assign valid_o         = valid_q;
  assign res_o.value_out = has_q ? mem_rdata : '0;
  assign res_o.has_value = has_q;
  assign res_o.is_last   = last_q;
  assign res_o.status    = status_q;
  assign res_o.count_left = 11'(cntout_q);

  `ASSERT_NEVER(a_cnt_bound, cnt_q > CntW'(Depth), "element count above depth")
  `ASSERT_CLK(a_one_result, accept |=> valid_o, "transfer without result")
  `ASSERT_CLK(a_no_spurious, !accept |=> !valid_o, "result without transfer")
  `ASSERT_CLK(a_last_pop, valid_o && res_o.is_last |-> res_o.has_value && res_o.count_left == '0, "last flag without pop")
  `ASSERT_CLK(a_err_rise, $rose(err_q) |-> $past(accept) && $past(req_i.func) == FnDelete, "error set by other than delete")

endmodule
